@@ hw/rtl/sliding_window_average_assert.svh @@
// ---------------------------------------------------------------------------
// sliding window average assertion macros
// shorthand for clocked checks with reset masking
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_ASSERT_SVH

// condition must hold at every edge out of reset
`define SWA_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/swa_pkg.sv @@
// ---------------------------------------------------------------------------
// swa_pkg
// shared constants of the sliding window average block
// ---------------------------------------------------------------------------
package swa_pkg;

	// width of the window length register
	localparam int LEN_BITS = 10;

	// window length after reset
	localparam int RESET_LENGTH = 8;

	// parameter defaults
	localparam int MAX_WINDOW_DEFAULT  = 512;
	localparam int SAMPLE_BITS_DEFAULT = 16;

endpackage

@@ hw/rtl/sliding_window_average.sv @@
// ---------------------------------------------------------------------------
// sliding_window_average
// boxcar moving average over a ring buffer of recent samples
// ---------------------------------------------------------------------------
// Each request carries one signed sample and yields one result: the sample
// echoed, the average of the last window_length samples (sum divided by the
// length, truncated toward zero) and a flag that is set once the window is
// full; while the window fills the average reads 0. A window_length of 0
// acts as 1 and values above MAX_WINDOW act as MAX_WINDOW. Every write of
// window_length, even with the same value, empties the window. One sample is
// in flight at a time. A sample that fills or slides a full window goes
// through the bit-serial divider, which retires one quotient bit per cycle;
// a sample into a window still filling skips the division. The ring buffer
// is a single-port-per-side synchronous memory: the old sample is read in
// the accept cycle and overwritten in the cycle after. The result sits in an
// output register, so a new sample is taken while the previous result still
// waits downstream.
// ---------------------------------------------------------------------------
`include "sliding_window_average_assert.svh"

module sliding_window_average #(
	parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEFAULT,
	parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swa_pkg::LEN_BITS-1:0]        window_length,
	// sample requests
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	// results
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_echo,
	output logic signed [SAMPLE_BITS-1:0]       average,
	output logic                                average_valid
);

	// longest usable window: bounded by the memory and by the register width
	localparam int LEN_LIMIT = (1 << swa_pkg::LEN_BITS) - 1;
	localparam int MAX_LEN   = (MAX_WINDOW < LEN_LIMIT) ? MAX_WINDOW : LEN_LIMIT;
	localparam int RST_LEN   = (swa_pkg::RESET_LENGTH > MAX_LEN) ? MAX_LEN
		: swa_pkg::RESET_LENGTH;
	localparam int ADDR_BITS = $clog2(MAX_WINDOW);
	localparam int POS_BITS  = $clog2(MAX_LEN);
	localparam int ELW       = $clog2(MAX_LEN + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_LEN);
	localparam int CNT_BITS  = $clog2(SUM_BITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_UPD  = 5'b00010,
		S_LOAD = 5'b00100,
		S_DIV  = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t state_q;

	// window state
	logic [ELW-1:0]             len_q;
	logic [ELW-1:0]             fill_q;
	logic [POS_BITS-1:0]        pos_q;
	logic signed [SUM_BITS-1:0] sum_q;

	// sample in flight
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          avg_valid_q;

	// divider
	logic [ELW-1:0]      rem_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                neg_q;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_echo_q;
	logic signed [SAMPLE_BITS-1:0] average_q;
	logic                          average_valid_q;

	// ring buffer
	logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] rd_data_q;

	logic in_acc;
	logic cfg_acc;
	logic out_free;

	logic [ELW-1:0]             cfg_len;
	logic                       win_full;
	logic [ELW-1:0]             fill_nx;
	logic                       valid_nx;
	logic signed [SUM_BITS-1:0] old_ext;
	logic signed [SUM_BITS-1:0] new_ext;
	logic signed [SUM_BITS-1:0] sum_nx;
	logic [ELW-1:0]             pos_inc;
	logic [SUM_BITS-1:0]        sum_mag;
	logic [ELW:0]               trial;
	logic [ELW:0]               trial_diff;
	logic                       trial_ge;
	logic [SAMPLE_BITS-1:0]     quo_low;

	// handshakes: requests only while idle, config wins a tie
	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign sample_echo   = sample_echo_q;
	assign average       = average_q;
	assign average_valid = average_valid_q;

	// clamp of the written window length
	always_comb begin
		if (window_length == '0) begin
			cfg_len = ELW'(1);
		end else if (int'(window_length) > MAX_LEN) begin
			cfg_len = ELW'(MAX_LEN);
		end else begin
			cfg_len = ELW'(window_length);
		end
	end

	// running sum update: oldest leaves once the window is full
	always_comb begin
		win_full = (fill_q == len_q);
		fill_nx  = win_full ? fill_q : fill_q + ELW'(1);
		valid_nx = (fill_nx == len_q);
		old_ext  = win_full
			? {{(SUM_BITS-SAMPLE_BITS){rd_data_q[SAMPLE_BITS-1]}}, rd_data_q}
			: '0;
		new_ext  = {{(SUM_BITS-SAMPLE_BITS){sample_s1[SAMPLE_BITS-1]}}, sample_s1};
		sum_nx   = sum_q - old_ext + new_ext;
		pos_inc  = ELW'(pos_q) + ELW'(1);
	end

	// one restoring division step, plus magnitude of the sum
	always_comb begin
		sum_mag    = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
		trial      = {rem_q, quo_q[SUM_BITS-1]};
		trial_diff = trial - {1'b0, len_q};
		trial_ge   = (trial >= {1'b0, len_q});
		quo_low    = quo_q[SAMPLE_BITS-1:0];
	end

	// ring buffer: read in the accept cycle, write back in the cycle after
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ring_mem[ADDR_BITS'(pos_q)] <= sample_s1;
		end
		if (in_acc) begin
			rd_data_q <= ring_mem[ADDR_BITS'(pos_q)];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
		end
		unique case (state_q)
			S_UPD: begin
				rem_q <= '0;
				quo_q <= '0;
				neg_q <= 1'b0;
			end
			S_LOAD: begin
				quo_q <= sum_mag;
				neg_q <= sum_q[SUM_BITS-1];
				cnt_q <= CNT_BITS'(SUM_BITS - 1);
			end
			S_DIV: begin
				rem_q <= trial_ge ? trial_diff[ELW-1:0] : trial[ELW-1:0];
				quo_q <= {quo_q[SUM_BITS-2:0], trial_ge};
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
			S_PUT: begin
				if (out_free) begin
					sample_echo_q   <= sample_s1;
					average_q       <= neg_q ? -quo_low : quo_low;
					average_valid_q <= avg_valid_q;
				end
			end
			default: begin
			end
		endcase
	end

	// control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= ELW'(RST_LEN);
			fill_q      <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			avg_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a finished result replaces the one leaving in the same cycle
			if (state_q == S_PUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				len_q  <= cfg_len;
				fill_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					sum_q       <= sum_nx;
					fill_q      <= fill_nx;
					pos_q       <= (pos_inc == len_q) ? '0 : pos_inc[POS_BITS-1:0];
					avg_valid_q <= valid_nx;
					// no division while the window is still filling
					state_q     <= valid_nx ? S_LOAD : S_PUT;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`SWA_ASSERT_ALWAYS(a_fill_bound, fill_q <= len_q, "fill count beyond window length")
	`SWA_ASSERT_ALWAYS(a_pos_bound, ELW'(pos_q) < len_q, "write position outside window")
	`SWA_ASSERT_NEXT(a_acc_upd, in_acc, state_q == S_UPD, "accepted sample not updated")
	`SWA_ASSERT_NEXT(a_put_out, state_q == S_PUT && out_free, out_valid_q,
		"finished result not presented")

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the sliding window average block
// ---------------------------------------------------------------------------
// Samples are sent one request at a time. Each accepted sample is run
// through a behavioral copy of the boxcar filter kept in this bench, and the
// result it should produce is queued. Every accepted result is compared
// field by field with the oldest queued one. A short table of directed
// requests comes first, then phases of random samples under many window
// lengths, with random idle bursts on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int LEN_BITS     = swa_pkg::LEN_BITS;
	localparam int RESET_LENGTH = swa_pkg::RESET_LENGTH;
	localparam int SAMPLE_W     = swa_pkg::SAMPLE_BITS_DEFAULT;
	localparam int WINDOW_MAX   = swa_pkg::MAX_WINDOW_DEFAULT;
	localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int RANDOM_ITEMS = 1300;
	// idling stops for this many samples at the end of the run
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 500000;
	// a little over the divider latency of a full window
	localparam int DRAIN_CYCLES = 40;
	localparam int PRINT_CAP    = 40;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one expected result
	typedef struct packed {
		sample_t echo;
		sample_t avg;
		logic    full;
	} average_t;

	typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		row_kind_t kind;
		logic      typed;
		sample_t   value;
		sample_t   avg;
		logic      full;
	} directed_row_t;

	// how random samples of a phase are drawn
	typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_SMALL, MIX_HELD} sample_mix_t;

	localparam int DIRECTED_ROWS = 25;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// reset length is 8: seven requests only fill the window
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh0000, 1'b0},
		// eighth sample fills it with the largest positive value
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b1},
		// first slide of a full window
		'{ROW_SAMPLE, 1'b0, 16'sh8000, 16'sh0000, 1'b0},
		// length 0 behaves as length 1
		'{ROW_CONFIG, 1'b0, 16'sd0,    16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh8000, 16'sh8000, 1'b1},
		'{ROW_SAMPLE, 1'b1, 16'sh0001, 16'sh0001, 1'b1},
		'{ROW_SAMPLE, 1'b1, 16'shFFFF, 16'shFFFF, 1'b1},
		// all ones clamps to the largest window, far from full
		'{ROW_CONFIG, 1'b0, 16'sd1023, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh0005, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'shFFFB, 16'sh0000, 1'b0},
		// negative odd sum truncates toward zero
		'{ROW_CONFIG, 1'b0, 16'sd2,    16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'shFFFD, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh0000, 16'shFFFF, 1'b1},
		// rewrite with the same length still restarts the window
		'{ROW_CONFIG, 1'b0, 16'sd2,    16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh0007, 16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh8000, 16'shC004, 1'b1},
		'{ROW_SAMPLE, 1'b1, 16'sh8000, 16'sh8000, 1'b1},
		'{ROW_CONFIG, 1'b0, 16'sd1,    16'sh0000, 1'b0},
		'{ROW_SAMPLE, 1'b1, 16'sh7FFF, 16'sh7FFF, 1'b1}
	};

	// dut ports; the inputs are known from time zero
	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [LEN_BITS-1:0] window_length = LEN_BITS'(RESET_LENGTH);
	logic                in_valid      = 1'b0;
	logic                in_stall;
	sample_t             sample        = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	sample_t             sample_echo;
	sample_t             average;
	logic                average_valid;

	// filter state as this bench sees it
	logic [LEN_BITS-1:0]     length_reg;
	sample_t                 history [WINDOW_MAX];
	logic signed [SUM_W-1:0] window_sum;
	int unsigned             slot;
	int unsigned             filled;

	average_t expected_averages [$];

	// run bookkeeping
	int  mismatch_count  = 0;
	int  checked_results = 0;
	int  samples_sent    = 0;
	int  random_sent     = 0;
	int  length_writes   = 0;
	int  cycles          = 0;
	int  idle_pct        = 25;
	bit  quiet           = 1'b0;
	int  stall_left      = 0;

	sliding_window_average u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_length (window_length),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_echo   (sample_echo),
		.average       (average),
		.average_valid (average_valid)
	);

	always #10 clk = ~clk;

	// one line per mismatch, printing capped so a dead block stays readable
	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// length the filter really uses: 0 acts as 1, above the ring acts as the ring
	function automatic int unsigned active_length();
		if (length_reg == '0)
			return 1;
		if (int'(length_reg) > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(length_reg);
	endfunction

	// any length write empties the window
	task automatic restart_window(input logic [LEN_BITS-1:0] len);
		length_reg = len;
		window_sum = '0;
		slot       = 0;
		filled     = 0;
	endtask

	// advance the filter by one sample and return the result it yields
	task automatic predict_average(input sample_t s, output average_t want);
		int unsigned len;
		int unsigned pos;
		len = active_length();
		pos = slot;
		if (pos >= len)
			pos = 0;
		// a full window drops its oldest sample first
		if (filled >= len) begin
			window_sum = window_sum - history[pos];
			filled = len;
		end else begin
			filled++;
		end
		history[pos] = s;
		window_sum = window_sum + s;
		pos++;
		if (pos >= len)
			pos = 0;
		slot = pos;
		want.echo = s;
		want.full = (filled >= len);
		// signed int division truncates toward zero
		want.avg = want.full ? SAMPLE_W'(int'(window_sum) / int'(len)) : '0;
	endtask

	// random idle burst ahead of a request, none in the quiet tail
	function automatic int pick_gap();
		if (!quiet && $urandom_range(0, 99) < idle_pct)
			return $urandom_range(1, 8);
		return 0;
	endfunction

	function automatic sample_t pick_sample(input sample_mix_t mix);
		case (mix)
			MIX_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh7FFE;
					3: return 16'sh8001;
					4: return 16'shFFFF;
					default: return SAMPLE_W'($urandom);
				endcase
			end
			// near zero, so negative sums often need truncation
			MIX_SMALL: return SAMPLE_W'(int'($urandom_range(0, 14)) - 7);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// one sample request; returns once accepted, with the predicted result
	task automatic send_sample(input sample_t value, input int gap, output average_t want);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_average(value, want);
		samples_sent++;
	endtask

	// length write, only once every queued result has come back
	task automatic write_window(input logic [LEN_BITS-1:0] len);
		in_valid <= 1'b0;
		while (expected_averages.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_valid     <= 1'b1;
		window_length <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		restart_window(len);
		length_writes++;
	endtask

	// one phase of random requests under a fixed window length
	task automatic run_phase(input logic [LEN_BITS-1:0] len, input int count,
			input sample_mix_t mix, input int idle, input sample_t held);
		average_t want;
		sample_t  value;
		idle_pct = idle;
		write_window(len);
		for (int k = 0; k < count; k++) begin
			// held mix fills the window with one value, then goes random
			if (mix == MIX_HELD && k < active_length())
				value = held;
			else
				value = pick_sample(mix == MIX_HELD ? MIX_UNIFORM : mix);
			send_sample(value, pick_gap(), want);
			expected_averages.push_back(want);
			random_sent++;
			if (random_sent >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
		end
	endtask

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 7);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		average_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_averages.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, echo %0d avg %0d",
					sample_echo, average));
			end else begin
				want = expected_averages.pop_front();
				if (sample_echo !== want.echo)
					report_mismatch($sformatf("result %0d sample_echo %0d, want %0d",
						checked_results, sample_echo, want.echo));
				if (average !== want.avg)
					report_mismatch($sformatf("result %0d average %0d, want %0d",
						checked_results, average, want.avg));
				if (average_valid !== want.full)
					report_mismatch($sformatf("result %0d average_valid %b, want %b",
						checked_results, average_valid, want.full));
			end
			checked_results++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, expected_averages.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		average_t            want;
		int                  pick;
		logic [LEN_BITS-1:0] len;
		int                  directed_count;

		restart_window(LEN_BITS'(RESET_LENGTH));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, starting at the reset length of 8
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				write_window(directed_rows[i].value[LEN_BITS-1:0]);
			end else begin
				send_sample(directed_rows[i].value, pick_gap(), want);
				if (directed_rows[i].typed) begin
					want.echo = directed_rows[i].value;
					want.avg  = directed_rows[i].avg;
					want.full = directed_rows[i].full;
				end
				expected_averages.push_back(want);
			end
		end
		directed_count = samples_sent;

		// fixed phases at the edges of the length range
		run_phase(LEN_BITS'(0), 40, MIX_EXTREME, 40, '0);
		run_phase(LEN_BITS'(1), 40, MIX_UNIFORM, 0, '0);
		run_phase(LEN_BITS'(2), 40, MIX_SMALL, 70, '0);
		run_phase(LEN_BITS'(WINDOW_MAX), 40, MIX_HELD, 15, 16'sh7FFF);
		run_phase(LEN_BITS'(WINDOW_MAX + 1), 20, MIX_UNIFORM, 40, '0);
		// largest window filled with the most negative value: sum at its floor
		run_phase(LEN_BITS'(1023), WINDOW_MAX + 20, MIX_HELD, 15, 16'sh8000);

		// random phases, mostly short windows
		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = length_reg;
			else if (pick == 1)
				len = LEN_BITS'($urandom_range(17, 64));
			else if (pick == 2)
				len = LEN_BITS'($urandom_range(0, 1023));
			else
				len = LEN_BITS'($urandom_range(1, 12));
			run_phase(len, $urandom_range(20, 80), sample_mix_t'($urandom_range(0, 2)),
				$urandom_range(0, 3) * 25, '0);
		end

		// let the last results come back, then the divider settle
		in_valid <= 1'b0;
		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d samples (%0d directed) under %0d window length writes",
			samples_sent, directed_count, length_writes);
		$display("%0d results compared in %0d cycles", checked_results, cycles);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/swa_pkg.sv
hw/rtl/sliding_window_average.sv
tb/tb.sv
